@@ rtl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types, constants and helpers of the triangle plane clipper
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int CW       = 32;
  localparam int NW       = 18;
  localparam int DW       = 53;
  localparam int STEPS    = 32;
  localparam int QDEPTH   = 2;
  localparam int DATA_W   = 320;

  localparam logic [31:0] COLOR_RED    = 32'hFF0000FF;
  localparam logic [31:0] COLOR_YELLOW = 32'hFFFF00FF;
  localparam logic [31:0] COLOR_GREEN  = 32'h00FF00FF;

  typedef logic [2:0][CW-1:0] vtx_t;
  typedef logic signed [DW-1:0] dist_t;

  typedef enum logic [2:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_HIGHLIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUT,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

  typedef struct packed {
    logic [2:0][CW-1:0] point;
    logic [2:0][NW-1:0] normal;
    logic               highlight;
  } cfg_t;

  typedef struct packed {
    vtx_t [2:0]     v;
    logic [31:0]    color;
    dist_t [2:0]    d;
    logic [2:0]     in_mask;
  } item_t;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] c;
  } sel_t;

  // inside vertices first, each group in input order
  function automatic sel_t vertex_order(input logic [2:0] mask);
    sel_t s;
    unique case (mask)
      3'b001:  s = '{a: 2'd0, b: 2'd1, c: 2'd2};
      3'b010:  s = '{a: 2'd1, b: 2'd0, c: 2'd2};
      3'b100:  s = '{a: 2'd2, b: 2'd0, c: 2'd1};
      3'b011:  s = '{a: 2'd0, b: 2'd1, c: 2'd2};
      3'b101:  s = '{a: 2'd0, b: 2'd2, c: 2'd1};
      3'b110:  s = '{a: 2'd1, b: 2'd2, c: 2'd0};
      default: s = '{a: 2'd0, b: 2'd1, c: 2'd2};
    endcase
    return s;
  endfunction

endpackage

@@ rtl/tpc_front.sv @@
// ----------------------------------------------------------------------------
// tpc_front
// accepts triangles, computes the three plane distances and classifies them
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // ax ay az bx by bz cx cy cz tri_color
  output logic              q_valid,
  input  logic              q_ready,
  output item_t             q_item
);

  logic               vld1, vld2, vld3, en;
  vtx_t [2:0]         vtx1, vtx2;
  logic [31:0]        color1, color2;
  logic signed [32:0] diff1 [3][3];
  logic signed [50:0] prod2 [3][3];
  item_t              item3;

  assign en       = !vld3 || q_ready;
  assign s_tready = en;
  assign q_valid  = vld3;
  assign q_item   = item3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else if (en) begin
      vld1 <= s_tvalid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtx1   <= s_tdata[287:0];
      color1 <= s_tdata[319:288];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          diff1[i][k] <= $signed({s_tdata[96*i+32*k+31], s_tdata[96*i+32*k +: 32]})
                       - $signed({cfg.point[k][31], cfg.point[k]});
        end
      end
      vtx2   <= vtx1;
      color2 <= color1;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod2[i][k] <= diff1[i][k] * $signed(cfg.normal[k]);
        end
      end
      item3.v     <= vtx2;
      item3.color <= color2;
      for (int i = 0; i < 3; i++) begin
        item3.d[i] <= DW'(prod2[i][0]) + DW'(prod2[i][1]) + DW'(prod2[i][2]);
        item3.in_mask[i] <= !(DW'(prod2[i][0]) + DW'(prod2[i][1])
                              + DW'(prod2[i][2]) < 0);
      end
    end
  end

endmodule

@@ rtl/tpc_fifo.sv @@
// ----------------------------------------------------------------------------
// tpc_fifo
// short queue of classified triangles between front and back
// ----------------------------------------------------------------------------
module tpc_fifo import tpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t      mem [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready  = cnt != 2'(QDEPTH);
  assign out_valid = cnt != 2'd0;
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

@@ rtl/tpc_cut.sv @@
// ----------------------------------------------------------------------------
// tpc_cut
// edge intersection: per coordinate a serial multiply-divide, one bit a cycle
// ----------------------------------------------------------------------------
module tpc_cut import tpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  vtx_t  vin,
  input  vtx_t  vout,
  input  dist_t din,
  input  dist_t dout,
  output logic  done,
  output vtx_t  res
);

  logic              busy;
  logic [5:0]        cnt;
  logic [DW-1:0]     da;
  logic [DW:0]       den;
  vtx_t              base;
  logic [2:0]        neg;
  logic [2:0][31:0]  mag;
  logic [2:0][DW:0]  rem;
  logic [2:0][32:0]  quo;
  logic [2:0][DW:0]  rem_next;
  logic [2:0][1:0]   digit;
  logic [DW+2:0]     t [3];
  logic signed [32:0] delta [3];
  logic [32:0]       off [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      delta[k] = $signed({vout[k][31], vout[k]}) - $signed({vin[k][31], vin[k]});
      t[k] = {1'b0, rem[k], 1'b0} + (mag[k][31] ? {3'b0, da} : '0);
      if (t[k] >= {1'b0, den, 1'b0}) begin
        rem_next[k] = (DW+1)'(t[k] - {1'b0, den, 1'b0});
        digit[k]    = 2'd2;
      end else if (t[k] >= {2'b0, den}) begin
        rem_next[k] = (DW+1)'(t[k] - {2'b0, den});
        digit[k]    = 2'd1;
      end else begin
        rem_next[k] = t[k][DW:0];
        digit[k]    = 2'd0;
      end
      off[k] = quo[k] + 33'({rem[k], 1'b0} >= {1'b0, den});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == 6'(STEPS)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      da   <= din;
      den  <= (DW+1)'($signed({din[DW-1], din}) - $signed({dout[DW-1], dout}));
      base <= vin;
      for (int k = 0; k < 3; k++) begin
        neg[k] <= delta[k][32];
        mag[k] <= delta[k][32] ? 32'(-delta[k]) : delta[k][31:0];
        rem[k] <= '0;
        quo[k] <= '0;
      end
    end else if (busy && cnt != 6'(STEPS)) begin
      for (int k = 0; k < 3; k++) begin
        mag[k] <= {mag[k][30:0], 1'b0};
        rem[k] <= rem_next[k];
        quo[k] <= {quo[k][31:0], 1'b0} + 33'(digit[k]);
      end
    end else if (busy) begin
      for (int k = 0; k < 3; k++) begin
        res[k] <= neg[k] ? base[k] - off[k][31:0] : base[k] + off[k][31:0];
      end
    end
  end

endmodule

@@ rtl/tpc_back.sv @@
// ----------------------------------------------------------------------------
// tpc_back
// sequences passed and clipped triangles into the output register, drops others
// ----------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              highlight,
  input  logic              q_valid,
  output logic              q_ready,
  input  item_t             q_item,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // out_ax .. out_cz, out_color
  output logic              m_tlast,   // last_of_run
  output logic [1:0]        m_tuser    // clips_added
);

  state_t      state, state_next;
  logic        ovalid, free, load, start, two;
  vtx_t [2:0]  ov, lv;
  logic [31:0] ocolor, lcolor, color;
  logic        olast, llast;
  logic [1:0]  oadded, ladded, ni;
  vtx_t        p0, p1, res0, res1;
  logic        done0, done1;
  sel_t        sel;
  logic        one_in;
  logic [1:0]  e0_out, e1_in;

  assign free     = !ovalid || m_tready;
  assign m_tvalid = ovalid;
  assign m_tdata  = {ocolor, ov};
  assign m_tlast  = olast;
  assign m_tuser  = oadded;

  assign ni     = 2'(q_item.in_mask[0]) + 2'(q_item.in_mask[1]) + 2'(q_item.in_mask[2]);
  assign sel    = vertex_order(q_item.in_mask);
  assign one_in = ni == 2'd1;
  assign e0_out = one_in ? sel.b : sel.c;
  assign e1_in  = one_in ? sel.a : sel.b;

  tpc_cut u_cut0 (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .vin  (q_item.v[sel.a]),
    .vout (q_item.v[e0_out]),
    .din  (q_item.d[sel.a]),
    .dout (q_item.d[e0_out]),
    .done (done0),
    .res  (res0)
  );

  tpc_cut u_cut1 (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .vin  (q_item.v[e1_in]),
    .vout (q_item.v[sel.c]),
    .din  (q_item.d[e1_in]),
    .dout (q_item.d[sel.c]),
    .done (done1),
    .res  (res1)
  );

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    load       = 1'b0;
    start      = 1'b0;
    lv         = q_item.v;
    lcolor     = q_item.color;
    llast      = 1'b1;
    ladded     = 2'd0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (ni == 2'd0) begin
            q_ready = 1'b1;
          end else if (ni == 2'd3) begin
            if (free) begin
              load    = 1'b1;
              q_ready = 1'b1;
            end
          end else begin
            start      = 1'b1;
            q_ready    = 1'b1;
            state_next = ST_CUT;
          end
        end
      end
      ST_CUT: begin
        if (done0 && done1) state_next = ST_EMIT0;
      end
      ST_EMIT0: begin
        if (free) begin
          load = 1'b1;
          if (two) begin
            lv         = '{res0, p1, p0};
            lcolor     = highlight ? COLOR_YELLOW : color;
            llast      = 1'b0;
            ladded     = 2'd2;
            state_next = ST_EMIT1;
          end else begin
            lv         = '{res1, res0, p0};
            lcolor     = highlight ? COLOR_RED : color;
            ladded     = 2'd1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT1: begin
        if (free) begin
          load       = 1'b1;
          lv         = '{res1, res0, p1};
          lcolor     = highlight ? COLOR_GREEN : color;
          ladded     = 2'd2;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) ovalid <= 1'b1;
      else if (m_tready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ov     <= lv;
      ocolor <= lcolor;
      olast  <= llast;
      oadded <= ladded;
    end
    if (start) begin
      p0    <= q_item.v[sel.a];
      p1    <= q_item.v[sel.b];
      color <= q_item.color;
      two   <= ni == 2'd2;
    end
  end

endmodule

@@ rtl/triangle_plane_clipper.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// clips one triangle per word against a configurable plane
// ----------------------------------------------------------------------------
// throughput: 1 pass-through or dropped triangle per cycle while the output is
//   not stalled; a clipped triangle holds the back end until the bit-serial edge
//   divider (32 steps) is done, and a two-vertex case emits two results in turn
// reset: synchronous, clears the queue, the output register and the plane to z = 0.1
module triangle_plane_clipper import tpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // ax ay az bx by bz cx cy cz tri_color
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // out_ax out_ay out_az .. out_cz out_color
  output logic              m_tlast,   // last_of_run
  output logic [1:0]        m_tuser,   // clips_added
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t  cfg;
  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point     <= '{32'd6554, 32'd0, 32'd0};
      cfg.normal    <= '{18'd65536, 18'd0, 18'd0};
      cfg.highlight <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POINT_X:   cfg.point[0]  <= cfg_data;
        REG_POINT_Y:   cfg.point[1]  <= cfg_data;
        REG_POINT_Z:   cfg.point[2]  <= cfg_data;
        REG_NORMAL_X:  cfg.normal[0] <= cfg_data[NW-1:0];
        REG_NORMAL_Y:  cfg.normal[1] <= cfg_data[NW-1:0];
        REG_NORMAL_Z:  cfg.normal[2] <= cfg_data[NW-1:0];
        REG_HIGHLIGHT: cfg.highlight <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_item  (f_item)
  );

  tpc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_item (b_item)
  );

  tpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .highlight(cfg.highlight),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_item   (b_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the triangle plane clipper against its own clipping predictor.
// triangles go in on the slave stream and each clipped or passed triangle is
// compared field by field with the next expected one. the plane and the
// highlight flag are changed between phases, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  typedef struct {
    logic [31:0] p [9];
    logic [31:0] color;
    logic        last;
    logic [1:0]  added;
  } tri_out_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic [1:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  triangle_plane_clipper dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  logic signed [63:0] pt [3];
  logic signed [63:0] nrm [3];
  logic hl;
  tri_out_t pending [$];
  int errors = 0;
  bit gaps_on = 1;
  int stall_left = 0;
  string coord_name [9] = '{"out_ax", "out_ay", "out_az", "out_bx", "out_by",
                            "out_bz", "out_cx", "out_cy", "out_cz"};

  function automatic logic signed [63:0] plane_dist(logic signed [63:0] v [3]);
    logic signed [63:0] s;
    s = 0;
    for (int k = 0; k < 3; k++) s += (v[k] - pt[k]) * nrm[k];
    return s;
  endfunction

  // a + (b - a) * da / (da - db), magnitude rounded half away from a
  function automatic logic signed [63:0] edge_cut(logic signed [63:0] a,
      logic signed [63:0] b, logic signed [63:0] da, logic signed [63:0] db);
    logic [127:0] num, den, q;
    logic signed [63:0] delta;
    logic [63:0] mag;
    delta = b - a;
    mag = delta < 0 ? -delta : delta;
    den = 128'(da - db);
    num = 2 * (128'(mag) * 128'(da)) + den;
    q = num / (2 * den);
    return delta < 0 ? a - 64'(q) : a + 64'(q);
  endfunction

  task automatic push_tri(logic signed [63:0] v [5][3], int a, int b, int c,
      logic [31:0] col, bit lst, logic [1:0] add);
    tri_out_t t;
    int idx [3];
    idx = '{a, b, c};
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) t.p[i*3+k] = v[idx[i]][k][31:0];
    t.color = col; t.last = lst; t.added = add;
    pending = {pending, t};
  endtask

  task automatic predict_clip(logic [DATA_W-1:0] w);
    logic signed [63:0] v [5][3];
    logic signed [63:0] d [3];
    logic signed [63:0] tmp [3];
    int ins [3], outs [3];
    int n_in, n_out;
    logic [31:0] col;
    col = w[9*32 +: 32];
    n_in = 0;
    n_out = 0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) v[i][k] = $signed(w[(i*3+k)*32 +: 32]);
      tmp = v[i];
      d[i] = plane_dist(tmp);
      if (d[i] >= 0) begin
        ins[n_in] = i;
        n_in++;
      end else begin
        outs[n_out] = i;
        n_out++;
      end
    end
    if (n_in == 3) begin
      push_tri(v, 0, 1, 2, col, 1, 0);
    end else if (n_in == 1) begin
      for (int k = 0; k < 3; k++) begin
        v[3][k] = edge_cut(v[ins[0]][k], v[outs[0]][k], d[ins[0]], d[outs[0]]);
        v[4][k] = edge_cut(v[ins[0]][k], v[outs[1]][k], d[ins[0]], d[outs[1]]);
      end
      push_tri(v, ins[0], 3, 4, hl ? COLOR_RED : col, 1, 1);
    end else if (n_in == 2) begin
      for (int k = 0; k < 3; k++) begin
        v[3][k] = edge_cut(v[ins[0]][k], v[outs[0]][k], d[ins[0]], d[outs[0]]);
        v[4][k] = edge_cut(v[ins[1]][k], v[outs[0]][k], d[ins[1]], d[outs[0]]);
      end
      push_tri(v, ins[0], ins[1], 3, hl ? COLOR_YELLOW : col, 0, 2);
      push_tri(v, ins[1], 3, 4, hl ? COLOR_GREEN : col, 1, 2);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx) inside
      REG_POINT_X, REG_POINT_Y, REG_POINT_Z: pt[idx] = $signed(val);
      REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z:
        nrm[idx-3] = $signed(val[17:0]);
      default: hl = val[0];
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_plane(logic [31:0] px, py, pz, nx, ny, nz, logic h);
    write_reg(REG_POINT_X, px); write_reg(REG_POINT_Y, py);
    write_reg(REG_POINT_Z, pz); write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny); write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_HIGHLIGHT, {31'b0, h});
  endtask

  task automatic send_tri(logic [DATA_W-1:0] w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1; s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    predict_clip(w);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return $urandom;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_tri(int mode);
    logic [DATA_W-1:0] w;
    for (int i = 0; i < 9; i++) w[i*32 +: 32] = rand_coord(mode);
    w[9*32 +: 32] = $urandom;
    return w;
  endfunction

  // z coordinates 0.0 or 1.0 per vertex, over the default near plane
  function automatic logic [DATA_W-1:0] z_tri(logic [2:0] inmask, logic [31:0] col);
    logic [DATA_W-1:0] w;
    w = rand_tri(2);
    for (int i = 0; i < 3; i++) w[(i*3+2)*32 +: 32] = inmask[i] ? 32'h10000 : 32'h0;
    w[9*32 +: 32] = col;
    return w;
  endfunction

  // consumer side: random stall bursts, checks each word
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (!gaps_on) begin
      m_tready <= 1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected triangle out");
        errors++;
      end else begin
        tri_out_t e;
        e = pending[0];
        pending.delete(0);
        for (int i = 0; i < 9; i++)
          if (m_tdata[i*32 +: 32] !== e.p[i]) begin
            $error("%s: expected %h actual %h", coord_name[i], e.p[i],
                   m_tdata[i*32 +: 32]);
            errors++;
          end
        if (m_tdata[9*32 +: 32] !== e.color) begin
          $error("out_color: expected %h actual %h", e.color, m_tdata[9*32 +: 32]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_of_run: expected %b actual %b", e.last, m_tlast);
          errors++;
        end
        if (m_tuser !== e.added) begin
          $error("clips_added: expected %0d actual %0d", e.added, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_directed;
    logic [DATA_W-1:0] w;
    for (int m = 0; m < 8; m++) send_tri(z_tri(3'(m), 32'hDEADBEEF));
    send_tri('0);
    send_tri({32'hFFFFFFFF, {9{32'h7FFFFFFF}}});
    send_tri({32'h0, {9{32'h80000000}}});
    w = z_tri(3'b001, 32'h12345678);
    w[2*32 +: 32] = 32'd6554;
    send_tri(w);
    drain();
    set_plane(32'h80000000, 32'h7FFFFFFF, 0, 32'h10000, 32'hFFFF0000, 0, 1'b1);
    for (int m = 0; m < 6; m++) send_tri(rand_tri(m % 3));
    drain();
    set_plane(0, 0, 0, 0, 0, 0, 1'b1);
    send_tri(rand_tri(1)); send_tri(rand_tri(0));
    drain();
  endtask

  task automatic test_highlight_modes;
    set_plane(0, 0, 32'd6554, 0, 0, 32'h10000, 1'b1);
    for (int m = 0; m < 8; m++) send_tri(z_tri(3'(m), $urandom));
    drain();
  endtask

  task automatic test_random_planes;
    for (int ph = 0; ph < 12; ph++) begin
      logic [31:0] n [3];
      for (int k = 0; k < 3; k++)
        case ($urandom_range(0, 3))
          0: n[k] = 32'h10000;
          1: n[k] = 32'hFFFF0000;
          2: n[k] = $urandom;
          default: n[k] = 32'($signed($urandom_range(0, 131072)) - 65536);
        endcase
      set_plane(rand_coord(ph % 3), rand_coord(2), rand_coord(ph % 2 ? 1 : 2),
                n[0], n[1], n[2], 1'($urandom_range(0, 1)));
      if (ph == 11) gaps_on = 0;
      for (int i = 0; i < 100; i++) send_tri(rand_tri($urandom_range(0, 9) == 0 ? 0 :
                                           $urandom_range(1, 2)));
      drain();
    end
  endtask

  initial begin
    pt = '{0, 0, 6554};
    nrm = '{0, 0, 65536};
    hl = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_highlight_modes();
    test_random_planes();
    if (errors == 0) $display("triangle_plane_clipper verification clean");
    else $display("triangle_plane_clipper verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("triangle_plane_clipper verification failed");
    $finish;
  end
endmodule
